FILE: rtl/gn3_pkg.sv
// Shared constants, types and helpers for the 3D gradient noise pipeline.
`timescale 1ns / 1ps
package gn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;
  localparam int POS_W      = 32;
  localparam int POS_FRAC   = 16;
  localparam int GRAD_W     = 16;
  localparam int GRAD_FRAC  = 14;
  localparam int OUT_FRAC   = 14;
  localparam int OUT_W      = 17;
  localparam int MAX_OCT    = 8;
  localparam int OCT_W      = (MAX_OCT > 1) ? $clog2(MAX_OCT) : 1;
  localparam int CNT_W      = 4;
  localparam int NCORNER    = 8;
  localparam int GCOPIES    = NCORNER / 2;

  // Datapath widths.
  localparam int W_W         = POS_FRAC + 1;            // smoothed weight, up to one
  localparam int WXY_W       = POS_FRAC + 2;            // weight products
  localparam int OFF_W       = POS_FRAC + 1;            // signed corner offset
  localparam int DOTF_W      = GRAD_W + OFF_W + 2;      // full dot product
  localparam int DOT_W       = DOTF_W - POS_FRAC;       // floored dot product
  localparam int PROD_W      = DOT_W + WXY_W + 1;
  localparam int PSUM_W      = PROD_W + 1;
  localparam int SUM_W       = PSUM_W + 2;
  localparam int BLEND_SHIFT = GRAD_FRAC + POS_FRAC - OUT_FRAC;
  localparam int NOISE_W     = SUM_W - BLEND_SHIFT;
  localparam int ACC_W       = NOISE_W + MAX_OCT + OCT_W;

  typedef enum logic [1:0] {
    OP_PERM = 2'd0,
    OP_GRAD = 2'd1,
    OP_EVAL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] REG_NOISE_MODE   = 2'd0;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic             turb;
    logic             zero;
    logic             first;
    logic             last;
    logic [OCT_W-1:0] oct;
  } meta_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed((ACC_W)'((1 << (OUT_W - 1)) - 1));
    lo = ~hi;
    if (v > hi) begin
      sat_out = {1'b0, {(OUT_W - 1){1'b1}}};
    end else if (v < lo) begin
      sat_out = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/gradient_noise_3d.sv
// Top level of the 3D gradient noise and turbulence pipeline.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_ready_o  op, axis, table_index, perm_value,
//                                              grad_x/y/z, pos_x/y/z
// out      source     out_valid_o / out_ready_i noise_value
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// One pipeline slot is issued per cycle while the output is not stalled. Plain
// noise, table loads and a turbulence item with zero octaves take one slot; a
// turbulence item takes one slot per octave (up to eight), and the next beat
// is not taken until the last slot of the item is issued.
// Reset clears control state only; the tables hold garbage until loaded.
// A stalled output beat freezes every stage, so nothing is lost or repeated.
module gradient_noise_3d (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [1:0]          axis_i,
  input  logic [7:0]          table_index_i,
  input  logic [7:0]          perm_value_i,
  input  logic signed [15:0]  grad_x_i,
  input  logic signed [15:0]  grad_y_i,
  input  logic signed [15:0]  grad_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  noise_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [3:0]          cfg_data_i
);

  logic                                       adv;
  logic                                       mode_q;
  logic [gn3_pkg::CNT_W-1:0]                  oct_cnt_q;

  gn3_pkg::meta_t                             meta1, meta3, meta8;
  logic [2:0][gn3_pkg::POS_W-1:0]             pos1;
  logic [1:0]                                 axis1;
  logic [gn3_pkg::IDX_W-1:0]                  idx1;
  logic [gn3_pkg::PERM_W-1:0]                 perm1;
  logic [3*gn3_pkg::GRAD_W-1:0]               grad1;
  logic [2:0][gn3_pkg::POS_FRAC-1:0]          frac3;
  logic [2:0][gn3_pkg::W_W-1:0]               sm3;
  logic [gn3_pkg::NCORNER-1:0][3*gn3_pkg::GRAD_W-1:0] grad3;
  logic signed [gn3_pkg::NOISE_W-1:0]         noise8;

  logic signed [gn3_pkg::ACC_W-1:0]           acc_q;
  logic signed [gn3_pkg::ACC_W-1:0]           noise_ext;
  logic signed [gn3_pkg::ACC_W-1:0]           term;
  logic signed [gn3_pkg::ACC_W-1:0]           acc_d;
  logic signed [gn3_pkg::ACC_W-1:0]           mag;
  logic [gn3_pkg::OCT_W-1:0]                  shamt;
  logic [gn3_pkg::OUT_W-1:0]                  result;
  logic                                       emit;
  logic                                       out_valid_q;
  logic [gn3_pkg::OUT_W-1:0]                  noise_q;

  // The whole pipeline moves unless a result beat is waiting at the output.
  assign adv = !out_valid_q || out_ready_i;

  // Configuration registers; writes always land.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      oct_cnt_q <= (gn3_pkg::CNT_W)'(7);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gn3_pkg::REG_NOISE_MODE:   mode_q    <= cfg_data_i[0];
        gn3_pkg::REG_OCTAVE_COUNT: oct_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gn3_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .axis_i         (axis_i),
    .table_index_i  (table_index_i),
    .perm_value_i   (perm_value_i),
    .grad_i         ({grad_z_i, grad_y_i, grad_x_i}),
    .pos_i          ({pos_z_i, pos_y_i, pos_x_i}),
    .noise_mode_i   (mode_q),
    .octave_count_i (oct_cnt_q),
    .meta_o         (meta1),
    .pos_o          (pos1),
    .axis_o         (axis1),
    .index_o        (idx1),
    .perm_o         (perm1),
    .grad_o         (grad1)
  );

  gn3_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .meta_i  (meta1),
    .pos_i   (pos1),
    .axis_i  (axis1),
    .index_i (idx1),
    .perm_i  (perm1),
    .grad_i  (grad1),
    .meta_o  (meta3),
    .frac_o  (frac3),
    .sm_o    (sm3),
    .grad_o  (grad3)
  );

  gn3_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .meta_i  (meta3),
    .frac_i  (frac3),
    .sm_i    (sm3),
    .grad_i  (grad3),
    .meta_o  (meta8),
    .noise_o (noise8)
  );

  // Octave accumulation: octave o is weighted by 2^(MAX_OCT-1-o) so the
  // running sum stays exact; the final beat takes |sum| and drops the guard.
  always_comb begin
    noise_ext = (gn3_pkg::ACC_W)'(noise8);
    shamt     = (gn3_pkg::OCT_W)'(gn3_pkg::MAX_OCT - 1) - meta8.oct;
    term      = noise_ext <<< shamt;
    acc_d     = (meta8.first ? '0 : acc_q) + term;
    mag       = acc_d[gn3_pkg::ACC_W-1] ? -acc_d : acc_d;
    if (!meta8.turb) begin
      result = gn3_pkg::sat_out(noise_ext);
    end else if (meta8.zero) begin
      result = '0;
    end else begin
      result = gn3_pkg::sat_out(mag >>> (gn3_pkg::MAX_OCT - 1));
    end
  end

  assign emit = meta8.valid && (meta8.op == gn3_pkg::OP_EVAL) && meta8.last;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (meta8.valid && (meta8.op == gn3_pkg::OP_EVAL) && meta8.turb) begin
        acc_q <= acc_d;
      end
      if (emit) begin
        noise_q <= result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = $signed(noise_q);

endmodule

FILE: rtl/gn3_front.sv
// Input stage: takes beats and issues one pipeline slot per beat, or one per octave for turbulence.
`timescale 1ns / 1ps
module gn3_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       adv_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [1:0]                                 op_i,
  input  logic [1:0]                                 axis_i,
  input  logic [7:0]                                 table_index_i,
  input  logic [7:0]                                 perm_value_i,
  input  logic [2:0][gn3_pkg::GRAD_W-1:0]            grad_i,
  input  logic [2:0][gn3_pkg::POS_W-1:0]             pos_i,
  input  logic                                       noise_mode_i,
  input  logic [gn3_pkg::CNT_W-1:0]                  octave_count_i,
  output gn3_pkg::meta_t                             meta_o,
  output logic [2:0][gn3_pkg::POS_W-1:0]             pos_o,
  output logic [1:0]                                 axis_o,
  output logic [gn3_pkg::IDX_W-1:0]                  index_o,
  output logic [gn3_pkg::PERM_W-1:0]                 perm_o,
  output logic [3*gn3_pkg::GRAD_W-1:0]               grad_o
);

  logic                                f_valid_q;
  gn3_pkg::op_e                        f_op_q;
  logic                                f_turb_q;
  logic                                f_zero_q;
  logic [gn3_pkg::OCT_W-1:0]           f_oct_q;
  logic [gn3_pkg::OCT_W-1:0]           f_nlast_q;
  logic [1:0]                          f_axis_q;
  logic [gn3_pkg::IDX_W-1:0]           f_idx_q;
  logic [gn3_pkg::PERM_W-1:0]          f_perm_q;
  logic [3*gn3_pkg::GRAD_W-1:0]        f_grad_q;
  logic [2:0][gn3_pkg::POS_W-1:0]      f_pos_q;
  logic                                f_last;
  logic                                take;
  logic [gn3_pkg::CNT_W-1:0]           oct_sat;
  logic [gn3_pkg::OCT_W-1:0]           nlast_new;

  assign f_last = (f_op_q != gn3_pkg::OP_EVAL) || f_zero_q || (f_oct_q == f_nlast_q);
  assign in_ready_o = adv_i && (!f_valid_q || f_last);
  assign take = in_valid_i && in_ready_o;

  assign oct_sat = (octave_count_i > (gn3_pkg::CNT_W)'(gn3_pkg::MAX_OCT)) ?
                   (gn3_pkg::CNT_W)'(gn3_pkg::MAX_OCT) : octave_count_i;
  assign nlast_new = noise_mode_i ? (gn3_pkg::OCT_W)'(oct_sat - 1'b1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_op_q    <= gn3_pkg::OP_NONE;
      f_turb_q  <= 1'b0;
      f_zero_q  <= 1'b0;
      f_oct_q   <= '0;
      f_nlast_q <= '0;
    end else if (adv_i) begin
      if (f_valid_q && !f_last) begin
        // advance to the next octave of the same item
        f_oct_q <= f_oct_q + 1'b1;
      end else begin
        f_valid_q <= in_valid_i;
        f_op_q    <= gn3_pkg::op_e'(op_i);
        f_turb_q  <= noise_mode_i;
        f_zero_q  <= noise_mode_i && (octave_count_i == '0);
        f_oct_q   <= '0;
        f_nlast_q <= nlast_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (f_valid_q && !f_last) begin
        for (int a = 0; a < 3; a++) begin
          f_pos_q[a] <= {f_pos_q[a][gn3_pkg::POS_W-2:0], 1'b0};
        end
      end else if (take) begin
        f_axis_q <= axis_i;
        f_idx_q  <= (gn3_pkg::IDX_W)'(table_index_i);
        f_perm_q <= perm_value_i;
        f_grad_q <= {grad_i[2], grad_i[1], grad_i[0]};
        f_pos_q  <= pos_i;
      end
    end
  end

  always_comb begin
    meta_o.valid = f_valid_q;
    meta_o.op    = f_valid_q ? f_op_q : gn3_pkg::OP_NONE;
    meta_o.turb  = f_turb_q;
    meta_o.zero  = f_zero_q;
    meta_o.first = (f_oct_q == '0);
    meta_o.last  = f_last;
    meta_o.oct   = f_oct_q;
  end

  assign pos_o   = f_pos_q;
  assign axis_o  = f_axis_q;
  assign index_o = f_idx_q;
  assign perm_o  = f_perm_q;
  assign grad_o  = f_grad_q;

endmodule

FILE: rtl/gn3_lookup.sv
// Table stages: permutation lookup, hashing, gradient fetch and smoothing.
`timescale 1ns / 1ps
module gn3_lookup (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             adv_i,
  input  gn3_pkg::meta_t                                   meta_i,
  input  logic [2:0][gn3_pkg::POS_W-1:0]                   pos_i,
  input  logic [1:0]                                       axis_i,
  input  logic [gn3_pkg::IDX_W-1:0]                        index_i,
  input  logic [gn3_pkg::PERM_W-1:0]                       perm_i,
  input  logic [3*gn3_pkg::GRAD_W-1:0]                     grad_i,
  output gn3_pkg::meta_t                                   meta_o,
  output logic [2:0][gn3_pkg::POS_FRAC-1:0]                frac_o,
  output logic [2:0][gn3_pkg::W_W-1:0]                     sm_o,
  output logic [gn3_pkg::NCORNER-1:0][3*gn3_pkg::GRAD_W-1:0] grad_o
);

  logic [gn3_pkg::PERM_W-1:0]   px_mem [gn3_pkg::TABLE_SIZE];
  logic [gn3_pkg::PERM_W-1:0]   py_mem [gn3_pkg::TABLE_SIZE];
  logic [gn3_pkg::PERM_W-1:0]   pz_mem [gn3_pkg::TABLE_SIZE];
  logic [3*gn3_pkg::GRAD_W-1:0] g_mem  [gn3_pkg::GCOPIES][gn3_pkg::TABLE_SIZE];

  gn3_pkg::meta_t                                   m2_q, m3_q;
  logic [2:0][gn3_pkg::POS_FRAC-1:0]                frac2_q, frac3_q;
  logic [2:0][gn3_pkg::POS_FRAC-1:0]                sq2_q;
  logic [2:0][1:0][gn3_pkg::PERM_W-1:0]             perm2_q;
  logic [gn3_pkg::IDX_W-1:0]                        idx2_q;
  logic [3*gn3_pkg::GRAD_W-1:0]                     gw2_q;
  logic [2:0][gn3_pkg::W_W-1:0]                     sm3_q;
  logic [gn3_pkg::NCORNER-1:0][3*gn3_pkg::GRAD_W-1:0] grad3_q;

  logic [2:0][gn3_pkg::IDX_W-1:0]                   cell_lo, cell_hi;
  logic [2:0][gn3_pkg::POS_FRAC-1:0]                frac1;
  logic [2:0][2*gn3_pkg::POS_FRAC-1:0]              sq_full;
  logic [2:0][gn3_pkg::POS_FRAC+1:0]                factor;
  logic [2:0][3*gn3_pkg::POS_FRAC+1:0]              sm_full;
  logic [gn3_pkg::NCORNER-1:0][gn3_pkg::IDX_W-1:0]  hash;
  logic                                             perm_wr;
  logic                                             grad_wr;

  // Stage one: cell, fraction and fraction squared.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_lo[a] = pos_i[a][gn3_pkg::POS_FRAC +: gn3_pkg::IDX_W];
      cell_hi[a] = cell_lo[a] + 1'b1;
      frac1[a]   = pos_i[a][gn3_pkg::POS_FRAC-1:0];
      sq_full[a] = frac1[a] * frac1[a];
    end
  end

  assign perm_wr = meta_i.valid && (meta_i.op == gn3_pkg::OP_PERM);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (perm_wr) begin
        case (axis_i)
          gn3_pkg::AXIS_X: px_mem[index_i] <= perm_i;
          gn3_pkg::AXIS_Y: py_mem[index_i] <= perm_i;
          gn3_pkg::AXIS_Z: pz_mem[index_i] <= perm_i;
          default: ;
        endcase
      end
      perm2_q[0][0] <= px_mem[cell_lo[0]];
      perm2_q[0][1] <= px_mem[cell_hi[0]];
      perm2_q[1][0] <= py_mem[cell_lo[1]];
      perm2_q[1][1] <= py_mem[cell_hi[1]];
      perm2_q[2][0] <= pz_mem[cell_lo[2]];
      perm2_q[2][1] <= pz_mem[cell_hi[2]];
      for (int a = 0; a < 3; a++) begin
        frac2_q[a] <= frac1[a];
        sq2_q[a]   <= sq_full[a][gn3_pkg::POS_FRAC +: gn3_pkg::POS_FRAC];
      end
      idx2_q <= index_i;
      gw2_q  <= grad_i;
    end
  end

  // Stage two: Hermite weight and corner hash.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      factor[a]  = (gn3_pkg::POS_FRAC + 2)'(3 << gn3_pkg::POS_FRAC)
                   - {1'b0, frac2_q[a], 1'b0};
      sm_full[a] = sq2_q[a] * factor[a];
    end
    for (int c = 0; c < gn3_pkg::NCORNER; c++) begin
      hash[c] = (gn3_pkg::IDX_W)'(perm2_q[0][(c >> 2) & 1]
                                  ^ perm2_q[1][(c >> 1) & 1]
                                  ^ perm2_q[2][c & 1]);
    end
  end

  assign grad_wr = m2_q.valid && (m2_q.op == gn3_pkg::OP_GRAD);

  // Each copy serves two corners; writes go to every copy.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (grad_wr) begin
        for (int k = 0; k < gn3_pkg::GCOPIES; k++) begin
          g_mem[k][idx2_q] <= gw2_q;
        end
      end
      for (int k = 0; k < gn3_pkg::GCOPIES; k++) begin
        grad3_q[2*k]   <= g_mem[k][hash[2*k]];
        grad3_q[2*k+1] <= g_mem[k][hash[2*k+1]];
      end
      for (int a = 0; a < 3; a++) begin
        frac3_q[a] <= frac2_q[a];
        sm3_q[a]   <= sm_full[a][gn3_pkg::POS_FRAC +: gn3_pkg::W_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= '0;
      m3_q <= '0;
    end else if (adv_i) begin
      m2_q <= meta_i;
      m3_q <= m2_q;
    end
  end

  assign meta_o = m3_q;
  assign frac_o = frac3_q;
  assign sm_o   = sm3_q;
  assign grad_o = grad3_q;

endmodule

FILE: rtl/gn3_blend.sv
// Blend stages: dot products, corner weights and the weighted corner sum.
`timescale 1ns / 1ps
module gn3_blend (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               adv_i,
  input  gn3_pkg::meta_t                                     meta_i,
  input  logic [2:0][gn3_pkg::POS_FRAC-1:0]                  frac_i,
  input  logic [2:0][gn3_pkg::W_W-1:0]                       sm_i,
  input  logic [gn3_pkg::NCORNER-1:0][3*gn3_pkg::GRAD_W-1:0] grad_i,
  output gn3_pkg::meta_t                                     meta_o,
  output logic signed [gn3_pkg::NOISE_W-1:0]                 noise_o
);

  localparam int NSTG = 5;

  gn3_pkg::meta_t                       mq [NSTG];

  logic signed [gn3_pkg::GRAD_W-1:0]    gv   [gn3_pkg::NCORNER][3];
  logic signed [gn3_pkg::OFF_W-1:0]     ov   [gn3_pkg::NCORNER][3];
  logic signed [gn3_pkg::DOTF_W-1:0]    dotf [gn3_pkg::NCORNER];
  logic [2:0][1:0][gn3_pkg::W_W-1:0]    w;
  logic [2*gn3_pkg::W_W-1:0]            wxy_full [4];
  logic [gn3_pkg::WXY_W+gn3_pkg::W_W-1:0] wt_full [gn3_pkg::NCORNER];
  logic signed [gn3_pkg::PROD_W-1:0]    prod_d [gn3_pkg::NCORNER];
  logic signed [gn3_pkg::SUM_W-1:0]     sum_d;

  logic signed [gn3_pkg::DOT_W-1:0]     dot4_q [gn3_pkg::NCORNER];
  logic signed [gn3_pkg::DOT_W-1:0]     dot5_q [gn3_pkg::NCORNER];
  logic [gn3_pkg::WXY_W-1:0]            wxy4_q [4];
  logic [1:0][gn3_pkg::W_W-1:0]         wz4_q;
  logic [gn3_pkg::WXY_W-1:0]            wt5_q  [gn3_pkg::NCORNER];
  logic signed [gn3_pkg::PROD_W-1:0]    prod6_q [gn3_pkg::NCORNER];
  logic signed [gn3_pkg::PSUM_W-1:0]    psum7_q [4];
  logic signed [gn3_pkg::NOISE_W-1:0]   noise8_q;

  // Dot products and per-axis weights; upper corner offset is frac - 1.
  always_comb begin
    for (int c = 0; c < gn3_pkg::NCORNER; c++) begin
      for (int a = 0; a < 3; a++) begin
        gv[c][a] = $signed(grad_i[c][a*gn3_pkg::GRAD_W +: gn3_pkg::GRAD_W]);
        ov[c][a] = $signed({((c >> (2 - a)) & 1) != 0, frac_i[a]});
      end
      dotf[c] = gv[c][0] * ov[c][0] + gv[c][1] * ov[c][1] + gv[c][2] * ov[c][2];
    end
    for (int a = 0; a < 3; a++) begin
      w[a][0] = (gn3_pkg::W_W)'(1 << gn3_pkg::POS_FRAC) - sm_i[a];
      w[a][1] = sm_i[a];
    end
    for (int j = 0; j < 4; j++) begin
      wxy_full[j] = w[0][(j >> 1) & 1] * w[1][j & 1];
    end
  end

  always_comb begin
    for (int c = 0; c < gn3_pkg::NCORNER; c++) begin
      wt_full[c] = wxy4_q[c >> 1] * wz4_q[c & 1];
      prod_d[c]  = dot5_q[c] * $signed({1'b0, wt5_q[c]});
    end
    sum_d = psum7_q[0] + psum7_q[1] + psum7_q[2] + psum7_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < gn3_pkg::NCORNER; c++) begin
        dot4_q[c]  <= dotf[c][gn3_pkg::DOTF_W-1:gn3_pkg::POS_FRAC];
        dot5_q[c]  <= dot4_q[c];
        wt5_q[c]   <= wt_full[c][gn3_pkg::POS_FRAC +: gn3_pkg::WXY_W];
        prod6_q[c] <= prod_d[c];
      end
      for (int j = 0; j < 4; j++) begin
        wxy4_q[j]  <= wxy_full[j][gn3_pkg::POS_FRAC +: gn3_pkg::WXY_W];
        psum7_q[j] <= prod6_q[2*j] + prod6_q[2*j+1];
      end
      wz4_q    <= w[2];
      noise8_q <= sum_d[gn3_pkg::SUM_W-1:gn3_pkg::BLEND_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        mq[s] <= '0;
      end
    end else if (adv_i) begin
      mq[0] <= meta_i;
      for (int s = 1; s < NSTG; s++) begin
        mq[s] <= mq[s-1];
      end
    end
  end

  assign meta_o  = mq[NSTG-1];
  assign noise_o = noise8_q;

endmodule

FILE: tb/sv/tb_gradient_noise_3d.sv
// Self-checking testbench for the 3D gradient noise and turbulence block.
`timescale 1ns / 1ps
module tb_gradient_noise_3d;

  localparam logic [1:0] AXIS_UNUSED = 2'd3;
  localparam int         DRAIN_CYC   = 40;   // extra wait once every expected result has arrived
  localparam int         STALL_LIMIT = 5000;

  typedef struct packed {
    gn3_pkg::op_e       op;
    logic [1:0]         axis;
    logic [7:0]         index;
    logic [7:0]         perm;
    logic signed [15:0] gx, gy, gz;
    logic signed [31:0] px, py, pz;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  beat_t              in_beat = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] noise_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [3:0]         cfg_data = '0;

  // Testbench copy of the block state.
  logic [7:0]         perm_x [256];
  logic [7:0]         perm_y [256];
  logic [7:0]         perm_z [256];
  logic signed [15:0] grad_tab [256][3];
  logic               turb_mode = 1'b0;
  logic [3:0]         octaves = 4'd7;

  beat_t              pending_q [$];
  logic signed [16:0] noise_q [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  logic               in_taken = 1'b0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 cyc = 0;
  int                 stall_mode = 0;

  gradient_noise_3d dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (in_beat.op),
    .axis_i        (in_beat.axis),
    .table_index_i (in_beat.index),
    .perm_value_i  (in_beat.perm),
    .grad_x_i      (in_beat.gx),
    .grad_y_i      (in_beat.gy),
    .grad_z_i      (in_beat.gz),
    .pos_x_i       (in_beat.px),
    .pos_y_i       (in_beat.py),
    .pos_z_i       (in_beat.pz),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .noise_value_o (noise_value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hermite weight 3t^2 - 2t^3 on a 16-bit fraction, truncating shifts.
  function automatic longint hermite(longint f);
    longint t;
    t = (f * f) >> 16;
    return (t * (3 * 65536 - 2 * f)) >> 16;
  endfunction

  // Single-octave noise value with 14 fraction bits.
  function automatic longint lattice_noise(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    logic [31:0] p [3];
    logic [7:0]  lat [3];
    longint      frac [3], sm [3], w [3];
    longint      acc, dot, wt, off;
    logic [7:0]  hidx;
    logic        d [3];
    p[0] = qx; p[1] = qy; p[2] = qz;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      lat[a]  = p[a][23:16];
      frac[a] = longint'(p[a][15:0]);
      sm[a]   = hermite(frac[a]);
    end
    for (int c = 0; c < 8; c++) begin
      d[0] = c[2]; d[1] = c[1]; d[2] = c[0];
      hidx = perm_x[8'(lat[0] + d[0])] ^ perm_y[8'(lat[1] + d[1])]
           ^ perm_z[8'(lat[2] + d[2])];
      dot = 0;
      for (int a = 0; a < 3; a++) begin
        off = frac[a] - (d[a] ? 65536 : 0);
        dot += longint'(grad_tab[hidx][a]) * off;
        w[a] = d[a] ? sm[a] : 65536 - sm[a];
      end
      wt = (((w[0] * w[1]) >> 16) * w[2]) >> 16;
      acc += (dot >>> 16) * wt;
    end
    return acc >>> 16;
  endfunction

  // Expected output for one evaluate beat under the current register settings.
  function automatic logic signed [16:0] noise_expected(beat_t b);
    longint r, sum;
    int     n;
    if (!turb_mode) begin
      r = lattice_noise(b.px, b.py, b.pz);
    end else begin
      n = (octaves > 8) ? 8 : int'(octaves);
      sum = 0;
      for (int o = 0; o < n; o++) begin
        sum += lattice_noise(b.px << o, b.py << o, b.pz << o) * (longint'(1) << (7 - o));
      end
      if (sum < 0) sum = -sum;
      r = sum >> 7;
    end
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return 17'(r);
  endfunction

  function automatic logic signed [15:0] rand_grad();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic beat_t eval_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    beat_t b;
    b = beat_t'({$urandom, $urandom, $urandom, $urandom});
    b.op = gn3_pkg::OP_EVAL; b.px = x; b.py = y; b.pz = z;
    return b;
  endfunction

  function automatic beat_t perm_beat(logic [1:0] ax, logic [7:0] i, logic [7:0] v);
    beat_t b;
    b = beat_t'({$urandom, $urandom, $urandom, $urandom});
    b.op = gn3_pkg::OP_PERM; b.axis = ax; b.index = i; b.perm = v;
    return b;
  endfunction

  function automatic beat_t grad_beat(logic [7:0] i, logic signed [15:0] x,
                                      logic signed [15:0] y, logic signed [15:0] z);
    beat_t b;
    b = beat_t'({$urandom, $urandom, $urandom, $urandom});
    b.op = gn3_pkg::OP_GRAD; b.index = i; b.gx = x; b.gy = y; b.gz = z;
    return b;
  endfunction

  // Random position: mostly full range, some near the cell grid and its wrap point.
  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      1:       return {8'($urandom), 8'($urandom_range(253, 255)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Mostly evaluates; sprinkle table rewrites, unused ops and unused-axis writes.
  function automatic beat_t rand_beat();
    beat_t   b;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      b = eval_beat(rand_pos(), rand_pos(), rand_pos());
    end else if (r < 86) begin
      b = perm_beat(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
    end else if (r < 92) begin
      b = grad_beat(8'($urandom), rand_grad(), rand_grad(), rand_grad());
    end else if (r < 96) begin
      b = beat_t'({$urandom, $urandom, $urandom, $urandom});
      b.op = gn3_pkg::OP_NONE;
    end else begin
      b = perm_beat(AXIS_UNUSED, 8'($urandom), 8'($urandom));
    end
    return b;
  endfunction

  // Sender: bursts of random length separated by random gaps; hold until taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_beat  <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between random stall styles, including a no-stall style.
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= (cyc % 7) < 4;
      default: out_ready <= $urandom_range(0, 5) == 0;
    endcase
  end

  // Monitor: update the state copy on accepted beats, check results.
  always @(posedge clk) begin
    logic signed [16:0] want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gn3_pkg::REG_NOISE_MODE) turb_mode = cfg_data[0];
        else if (cfg_index == gn3_pkg::REG_OCTAVE_COUNT) octaves = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (in_beat.op)
          gn3_pkg::OP_PERM: begin
            if (in_beat.axis == gn3_pkg::AXIS_X) perm_x[in_beat.index] = in_beat.perm;
            else if (in_beat.axis == gn3_pkg::AXIS_Y) perm_y[in_beat.index] = in_beat.perm;
            else if (in_beat.axis == gn3_pkg::AXIS_Z) perm_z[in_beat.index] = in_beat.perm;
          end
          gn3_pkg::OP_GRAD: begin
            grad_tab[in_beat.index][0] = in_beat.gx;
            grad_tab[in_beat.index][1] = in_beat.gy;
            grad_tab[in_beat.index][2] = in_beat.gz;
          end
          gn3_pkg::OP_EVAL: noise_q.push_back(noise_expected(in_beat));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (noise_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result noise_value=%0d", noise_value);
        end else begin
          want = noise_q.pop_front();
          if (noise_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("noise_value mismatch: expected %0d, got %0d", want, noise_value);
          end
        end
      end
      // Watchdog: count cycles where no channel moves a beat.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Wait until every queued beat is accepted and every result has arrived.
  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() > 0 || in_valid || noise_q.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic mode, logic [3:0] oct, int n);
    drain();
    write_reg(gn3_pkg::REG_NOISE_MODE, 4'(mode));
    write_reg(gn3_pkg::REG_OCTAVE_COUNT, oct);
    for (int i = 0; i < n; i++) pending_q.push_back(rand_beat());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Load every table entry before any evaluate; extreme gradients at the ends.
    for (int i = 0; i < 256; i++) begin
      pending_q.push_back(perm_beat(gn3_pkg::AXIS_X, 8'(i), 8'($urandom)));
      pending_q.push_back(perm_beat(gn3_pkg::AXIS_Y, 8'(i), 8'($urandom)));
      pending_q.push_back(perm_beat(gn3_pkg::AXIS_Z, 8'(i), 8'($urandom)));
      if (i < 4)
        pending_q.push_back(grad_beat(8'(i), 16'sd16384, -16'sd16384, 16'sd16384));
      else if (i > 251)
        pending_q.push_back(grad_beat(8'(i), -16'sd16384, 16'sd16384, -16'sd16384));
      else
        pending_q.push_back(grad_beat(8'(i), rand_grad(), rand_grad(), rand_grad()));
    end

    // Directed evaluates: zero, extremes, cell edges, lattice wrap.
    pending_q.push_back(eval_beat(32'h0, 32'h0, 32'h0));
    pending_q.push_back(eval_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(eval_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(eval_beat(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h00FF_8000));
    pending_q.push_back(eval_beat(32'h00FF_FFFF, 32'h0100_0000, 32'hFF00_0001));
    pending_q.push_back(eval_beat(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    pending_q.push_back(eval_beat(32'hAAAA_5555, 32'h5555_AAAA, 32'hCCCC_3333));
    // Unused op and unused axis leave the state alone.
    pending_q.push_back(beat_t'({2'(gn3_pkg::OP_NONE), {162{1'b1}}}));
    pending_q.push_back(perm_beat(AXIS_UNUSED, 8'hFF, 8'hFF));
    pending_q.push_back(eval_beat(32'h0003_4000, 32'hFFFE_C000, 32'h0001_0000));
    // Extreme gradient entry then evaluate through it.
    pending_q.push_back(grad_beat(8'hFF, 16'sd16384, 16'sd16384, 16'sd16384));
    pending_q.push_back(eval_beat(32'h0010_7FFF, 32'h0020_1234, 32'hFFF0_FEDC));

    // Register settings: plain, default turbulence, zero, max, above max, one, then plain again.
    run_phase(1'b0, 4'd7, 90);
    run_phase(1'b1, 4'd7, 80);
    for (int i = 0; i < 6; i++) pending_q.push_back(eval_beat($urandom, $urandom, $urandom));
    run_phase(1'b1, 4'd0, 50);
    run_phase(1'b1, 4'd8, 80);
    run_phase(1'b1, 4'd15, 40);
    run_phase(1'b1, 4'd1, 50);
    run_phase(1'b0, 4'd3, 60);
    drain();

    if (mismatches == 0 && noise_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
